>>> rtl/aes192_pkg.sv
// ----------------------------------------------------------------------------
// AES-192 package
// Shared types, constants, S-box tables and GF(2^8) helpers.
// ----------------------------------------------------------------------------
package aes192_pkg;

   localparam int unsigned BLOCK_W = 128;
   localparam int unsigned HALF_W  = 64;
   localparam int unsigned NUM_RK  = 13;
   localparam int unsigned RK_AW   = 4;
   localparam int unsigned WCNT_W  = 6;
   localparam int unsigned CSR_AW  = 2;

   localparam logic [CSR_AW-1:0] CSR_KEY_HIGH   = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_KEY_MIDDLE = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_KEY_LOW    = 2'd2;

   localparam logic [WCNT_W-1:0] LAST_WORD  = 6'd51;
   localparam logic [WCNT_W-1:0] LAST_ROUND = 6'd12;
   localparam logic [RK_AW-1:0]  LAST_RK    = 4'd12;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              load_block;
      logic              add_first;
      logic              do_round;
      logic              last_round;
      logic [RK_AW-1:0]  rk_addr;
      logic              exp_step;
      logic [WCNT_W-1:0] word_idx;
      logic              exp_rot;
      logic              out_load;
   } ctl_cmd_type;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] INV_SBOX [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] mix_col(input logic [31:0] c);
      logic [7:0] a0, a1, a2, a3;
      a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
      return {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
              a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
              a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
              xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
   endfunction

   // InvMixColumns as MixColumns after a pre-multiply by {04}x^2 + {05}.
   function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
      logic [7:0] a0, a1, a2, a3, u, v;
      a0 = c[31:24]; a1 = c[23:16]; a2 = c[15:8]; a3 = c[7:0];
      u = xtime(xtime(a0 ^ a2));
      v = xtime(xtime(a1 ^ a3));
      return mix_col({a0 ^ u, a1 ^ v, a2 ^ u, a3 ^ v});
   endfunction

   function automatic logic [BLOCK_W-1:0] inv_mix_block(input logic [BLOCK_W-1:0] s);
      return {inv_mix_col(s[127:96]), inv_mix_col(s[95:64]),
              inv_mix_col(s[63:32]), inv_mix_col(s[31:0])};
   endfunction

endpackage

>>> rtl/aes192_block_cipher.sv
// ----------------------------------------------------------------------------
// AES-192 block cipher
// Encrypts or decrypts one 128-bit block with a stored 192-bit key.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  req_     | in        | req_valid/stall    | func, data_hi, data_lo
//  rsp_     | out       | rsp_valid/stall    | result_hi, result_lo
//  csr_     | in        | csr_valid/ready    | index, data (key words)
//
// After the transfer the block goes through one key add and twelve rounds
// through a single round unit, then into the result register once it is free.
// The next block is taken only after that load, so one block is in work at a
// time; it is taken while a result still waits there.
// A key write starts an expansion of 52 key words, one key word per cycle through
// one S-box column; blocks are held off meanwhile. Round keys read as zero
// after reset until the first key write.
module aes192_block_cipher import aes192_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_func,
   input  logic [HALF_W-1:0] req_data_hi,
   input  logic [HALF_W-1:0] req_data_lo,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [HALF_W-1:0] rsp_result_hi,
   output logic [HALF_W-1:0] rsp_result_lo,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CSR_AW-1:0] csr_index,
   input  logic [HALF_W-1:0] csr_data
);

   ctl_cmd_type cmd;

   aes192_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .cmd       (cmd)
   );

   aes192_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .csr_we        (csr_valid && csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_func      (req_func),
      .req_data_hi   (req_data_hi),
      .req_data_lo   (req_data_lo),
      .rsp_result_hi (rsp_result_hi),
      .rsp_result_lo (rsp_result_lo)
   );

endmodule

>>> rtl/aes192_ctrl.sv
// ----------------------------------------------------------------------------
// AES-192 controller
// Sequences key expansion, cipher rounds and the result handoff.
// ----------------------------------------------------------------------------
module aes192_ctrl import aes192_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CSR_AW-1:0] csr_index,
   output ctl_cmd_type       cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_EXPAND = 2'd1;
   localparam logic [1:0] S_RUN    = 2'd2;
   localparam logic [1:0] S_DONE   = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [WCNT_W-1:0] cnt_ff, cnt_in;
   logic [2:0]        mod6_ff, mod6_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              key_write;
   logic              out_free;

   assign key_write = csr_valid && csr_ready &&
                      (csr_index == CSR_KEY_HIGH || csr_index == CSR_KEY_MIDDLE ||
                       csr_index == CSR_KEY_LOW);
   assign csr_ready = (state_ff == S_IDLE);
   assign req_stall = (state_ff != S_IDLE) || csr_valid;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      mod6_in      = mod6_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (key_write) begin
               state_in = S_EXPAND;
               cnt_in   = '0;
               mod6_in  = '0;
            end else if (req_valid && !req_stall) begin
               state_in       = S_RUN;
               cnt_in         = '0;
               cmd.load_block = 1'b1;
            end
         end
         S_EXPAND: begin
            cmd.exp_step = 1'b1;
            cmd.word_idx = cnt_ff;
            cmd.exp_rot  = (mod6_ff == 3'd0) && (cnt_ff != '0);
            mod6_in      = (mod6_ff == 3'd5) ? 3'd0 : mod6_ff + 3'd1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == LAST_WORD) begin
               state_in = S_IDLE;
            end
         end
         S_RUN: begin
            cmd.add_first  = (cnt_ff == '0);
            cmd.do_round   = (cnt_ff != '0);
            cmd.last_round = (cnt_ff == LAST_ROUND);
            cmd.rk_addr    = (cnt_ff == LAST_ROUND) ? LAST_RK : cnt_ff[RK_AW-1:0] + 1'b1;
            cnt_in         = cnt_ff + 1'b1;
            if (cnt_ff == LAST_ROUND) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         mod6_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         mod6_ff      <= mod6_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/aes192_dp.sv
// ----------------------------------------------------------------------------
// AES-192 datapath
// Key registers, key schedule, round key memories and the round unit.
// ----------------------------------------------------------------------------
module aes192_dp import aes192_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  ctl_cmd_type       cmd,
   input  logic              csr_we,
   input  logic [CSR_AW-1:0] csr_index,
   input  logic [HALF_W-1:0] csr_data,
   input  logic              req_func,
   input  logic [HALF_W-1:0] req_data_hi,
   input  logic [HALF_W-1:0] req_data_lo,
   output logic [HALF_W-1:0] rsp_result_hi,
   output logic [HALF_W-1:0] rsp_result_lo
);

   logic [HALF_W-1:0]  key_hi_ff, key_mid_ff, key_lo_ff;
   logic [31:0]        win_ff [6];
   logic [7:0]         rcon_ff;
   logic [95:0]        stage_ff;
   logic [BLOCK_W-1:0] enc_mem [NUM_RK];
   logic [BLOCK_W-1:0] dec_mem [NUM_RK];
   logic [NUM_RK-1:0]  vld_ff;
   logic [BLOCK_W-1:0] enc_rd_ff, dec_rd_ff;
   logic               rd_vld_ff;
   logic               func_ff;
   logic [BLOCK_W-1:0] state_ff, state_in;
   logic [HALF_W-1:0]  res_hi_ff, res_lo_ff;

   logic [HALF_W-1:0]  key_reg;
   logic [31:0]        key_word, rot_word, temp_word, new_word;
   logic [BLOCK_W-1:0] rk_full, rk_dec;
   logic [RK_AW-1:0]   wr_addr, dec_addr;
   logic               wr_row;
   logic [BLOCK_W-1:0] rk, enc_sub, dec_sub, enc_round, dec_round;

   // Key schedule: one word per cycle from a window of the last six words.
   always_comb begin
      case (cmd.word_idx[2:1])
         2'd0:    key_reg = key_hi_ff;
         2'd1:    key_reg = key_mid_ff;
         default: key_reg = key_lo_ff;
      endcase
      key_word  = cmd.word_idx[0] ? key_reg[31:0] : key_reg[63:32];
      rot_word  = {win_ff[5][23:0], win_ff[5][31:24]};
      temp_word = win_ff[5];
      if (cmd.exp_rot) begin
         temp_word = {SBOX[rot_word[31:24]] ^ rcon_ff, SBOX[rot_word[23:16]],
                      SBOX[rot_word[15:8]], SBOX[rot_word[7:0]]};
      end
      new_word = (cmd.word_idx < WCNT_W'(6)) ? key_word : (win_ff[0] ^ temp_word);
      rk_full  = {stage_ff, new_word};
      wr_addr  = cmd.word_idx[WCNT_W-1:2];
      dec_addr = LAST_RK - wr_addr;
      wr_row   = cmd.exp_step && (cmd.word_idx[1:0] == 2'd3);
      rk_dec   = (wr_addr == '0 || wr_addr == LAST_RK) ? rk_full : inv_mix_block(rk_full);
   end

   // Round unit. Byte 0 sits in the top bits; byte 4c+r is row r of column c.
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            enc_sub[127-8*(4*c+r) -: 8] = SBOX[state_ff[127-8*(4*((c+r)%4)+r) -: 8]];
            dec_sub[127-8*(4*((c+r)%4)+r) -: 8] = INV_SBOX[state_ff[127-8*(4*c+r) -: 8]];
         end
      end
      for (int c = 0; c < 4; c++) begin
         enc_round[127-32*c -: 32] = cmd.last_round ? enc_sub[127-32*c -: 32]
                                                    : mix_col(enc_sub[127-32*c -: 32]);
         dec_round[127-32*c -: 32] = cmd.last_round ? dec_sub[127-32*c -: 32]
                                                    : inv_mix_col(dec_sub[127-32*c -: 32]);
      end
      rk = rd_vld_ff ? (func_ff ? dec_rd_ff : enc_rd_ff) : '0;
      state_in = state_ff;
      if (cmd.load_block) begin
         state_in = {req_data_hi, req_data_lo};
      end else if (cmd.add_first) begin
         state_in = state_ff ^ rk;
      end else if (cmd.do_round) begin
         state_in = (func_ff ? dec_round : enc_round) ^ rk;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_hi_ff  <= '0;
         key_mid_ff <= '0;
         key_lo_ff  <= '0;
         vld_ff     <= '0;
         rd_vld_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_KEY_HIGH:   key_hi_ff  <= csr_data;
               CSR_KEY_MIDDLE: key_mid_ff <= csr_data;
               CSR_KEY_LOW:    key_lo_ff  <= csr_data;
               default: ;
            endcase
         end
         if (wr_row) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         rd_vld_ff <= vld_ff[cmd.rk_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exp_step) begin
         for (int k = 0; k < 5; k++) begin
            win_ff[k] <= win_ff[k+1];
         end
         win_ff[5] <= new_word;
         stage_ff  <= {stage_ff[63:0], new_word};
         if (cmd.word_idx == '0) begin
            rcon_ff <= 8'h01;
         end else if (cmd.exp_rot) begin
            rcon_ff <= xtime(rcon_ff);
         end
      end
      if (wr_row) begin
         enc_mem[wr_addr]  <= rk_full;
         dec_mem[dec_addr] <= rk_dec;
      end
      enc_rd_ff <= enc_mem[cmd.rk_addr];
      dec_rd_ff <= dec_mem[cmd.rk_addr];
      if (cmd.load_block) begin
         func_ff <= req_func;
      end
      state_ff <= state_in;
      if (cmd.out_load) begin
         res_hi_ff <= state_ff[127:64];
         res_lo_ff <= state_ff[63:0];
      end
   end

   assign rsp_result_hi = res_hi_ff;
   assign rsp_result_lo = res_lo_ff;

endmodule

>>> rtl/aes192_checker.sv
// ----------------------------------------------------------------------------
// AES-192 port checker
// Watches the ports of the block over time.
// ----------------------------------------------------------------------------
module aes192_checker import aes192_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic              csr_valid,
   input logic              csr_ready,
   input logic [CSR_AW-1:0] csr_index
);

   // A pending result is not dropped while the consumer stalls.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped under stall");

   // Once a block transfers, the block is busy on it.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall && !csr_ready)
      else $error("block not busy after transfer");

   // A key write blocks traffic during expansion.
   assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready && (csr_index == CSR_KEY_HIGH ||
      csr_index == CSR_KEY_MIDDLE || csr_index == CSR_KEY_LOW) |=> req_stall)
      else $error("block taken during key expansion");

   // A new result appears only after the block was busy.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without work");

endmodule

bind aes192_block_cipher aes192_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready),
   .csr_index (csr_index)
);

>>> tb/tb_aes192_block_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES-192 block cipher testbench
// Drives blocks in both directions under several keys and checks every result
// against a behavioral AES-192 computed in the bench, with random gaps on the
// request side and random stalls on the response side.
// ----------------------------------------------------------------------------
module tb_aes192_block_cipher;
   import aes192_pkg::*;

   // Index past the last key word; the block must ignore it.
   localparam logic [CSR_AW-1:0] CSR_UNMAPPED = 2'd3;
   localparam int unsigned WATCHDOG_LIMIT = 4000;
   localparam int unsigned SETTLE_CYCLES  = 40;

   typedef struct {
      logic              func;
      logic [HALF_W-1:0] data_hi;
      logic [HALF_W-1:0] data_lo;
   } block_req_type;

   typedef struct {
      logic [HALF_W-1:0] result_hi;
      logic [HALF_W-1:0] result_lo;
   } block_rsp_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_func = 1'b0;
   logic [HALF_W-1:0] req_data_hi = '0;
   logic [HALF_W-1:0] req_data_lo = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [HALF_W-1:0] rsp_result_hi;
   logic [HALF_W-1:0] rsp_result_lo;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [CSR_AW-1:0] csr_index = '0;
   logic [HALF_W-1:0] csr_data = '0;

   aes192_block_cipher uut (.*);

   always #5 clock = ~clock;

   // Bench copy of the key state.
   logic [HALF_W-1:0]  key_words [3];
   logic [BLOCK_W-1:0] enc_keys [NUM_RK];
   logic [BLOCK_W-1:0] dec_keys [NUM_RK];

   block_req_type pending_blocks [$];
   block_rsp_type expected_blocks [$];
   block_req_type driven_block;

   int unsigned fail_count = 0;
   int unsigned blocks_sent = 0;
   int unsigned blocks_checked = 0;
   int unsigned key_writes = 0;
   int unsigned idle_cycles = 0;
   int unsigned gap_left = 0;
   int unsigned burst_left = 0;
   int unsigned stall_mode = 0;
   int unsigned stall_left = 0;

   function automatic logic [7:0] gf_mult(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p;
      p = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[0]) p ^= a;
         a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
         b = b >> 1;
      end
      return p;
   endfunction

   function automatic logic [7:0] gf_invert(input logic [7:0] x);
      logic [7:0] r;
      r = 8'h01;
      // x^254 by repeated multiplication; zero maps to zero.
      for (int i = 0; i < 254; i++) r = gf_mult(r, x);
      return r;
   endfunction

   function automatic logic [7:0] rot8(input logic [7:0] v, input int n);
      return (v << n) | (v >> (8 - n));
   endfunction

   logic [7:0] fwd_sbox [256];
   logic [7:0] rev_sbox [256];

   function automatic logic [31:0] mix_word(input logic [31:0] w, input logic inverse);
      logic [7:0] a0, a1, a2, a3, m0, m1, m2, m3;
      a0 = w[31:24]; a1 = w[23:16]; a2 = w[15:8]; a3 = w[7:0];
      m0 = inverse ? 8'h0e : 8'h02; m1 = inverse ? 8'h0b : 8'h03;
      m2 = inverse ? 8'h0d : 8'h01; m3 = inverse ? 8'h09 : 8'h01;
      return {gf_mult(a0, m0) ^ gf_mult(a1, m1) ^ gf_mult(a2, m2) ^ gf_mult(a3, m3),
              gf_mult(a0, m3) ^ gf_mult(a1, m0) ^ gf_mult(a2, m1) ^ gf_mult(a3, m2),
              gf_mult(a0, m2) ^ gf_mult(a1, m3) ^ gf_mult(a2, m0) ^ gf_mult(a3, m1),
              gf_mult(a0, m1) ^ gf_mult(a1, m2) ^ gf_mult(a2, m3) ^ gf_mult(a3, m0)};
   endfunction

   function automatic logic [BLOCK_W-1:0] mix_state(input logic [BLOCK_W-1:0] s,
                                                     input logic inverse);
      return {mix_word(s[127:96], inverse), mix_word(s[95:64], inverse),
              mix_word(s[63:32], inverse), mix_word(s[31:0], inverse)};
   endfunction

   // Byte n of the state sits in bits 127-8n down; byte 4c+r is row r of column c.
   function automatic logic [BLOCK_W-1:0] sub_and_shift(input logic [BLOCK_W-1:0] s,
                                                         input logic inverse);
      logic [BLOCK_W-1:0] t;
      int src;
      t = '0;
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++) begin
            src = 4 * ((c + r) % 4) + r;
            if (inverse) t[127-8*src -: 8] = rev_sbox[s[127-8*(4*c+r) -: 8]];
            else t[127-8*(4*c+r) -: 8] = fwd_sbox[s[127-8*src -: 8]];
         end
      return t;
   endfunction

   function automatic void expand_key_schedule();
      logic [31:0] w [52];
      logic [31:0] t;
      logic [7:0]  rcon;
      rcon = 8'h01;
      for (int i = 0; i < 6; i++)
         w[i] = (i % 2 == 0) ? key_words[i/2][63:32] : key_words[i/2][31:0];
      for (int i = 6; i < 52; i++) begin
         t = w[i-1];
         if (i % 6 == 0) begin
            t = {t[23:0], t[31:24]};
            t = {fwd_sbox[t[31:24]], fwd_sbox[t[23:16]], fwd_sbox[t[15:8]], fwd_sbox[t[7:0]]};
            t ^= {rcon, 24'h0};
            rcon = gf_mult(rcon, 8'h02);
         end
         w[i] = w[i-6] ^ t;
      end
      for (int k = 0; k < NUM_RK; k++) enc_keys[k] = {w[4*k], w[4*k+1], w[4*k+2], w[4*k+3]};
      for (int k = 0; k < NUM_RK; k++)
         dec_keys[k] = (k == 0 || k == NUM_RK - 1) ? enc_keys[NUM_RK-1-k]
                                                   : mix_state(enc_keys[NUM_RK-1-k], 1'b1);
   endfunction

   function automatic block_rsp_type cipher_block(input block_req_type b);
      logic [BLOCK_W-1:0] s;
      block_rsp_type r;
      s = {b.data_hi, b.data_lo} ^ (b.func ? dec_keys[0] : enc_keys[0]);
      for (int k = 1; k < NUM_RK; k++) begin
         s = sub_and_shift(s, b.func);
         if (k != NUM_RK - 1) s = mix_state(s, b.func);
         s ^= b.func ? dec_keys[k] : enc_keys[k];
      end
      r.result_hi = s[127:64];
      r.result_lo = s[63:0];
      return r;
   endfunction

   // Request driver: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_blocks.push_back(cipher_block(driven_block));
            blocks_sent++;
         end
         if (!req_valid || !req_stall) begin
            if (burst_left == 0 && gap_left == 0) begin
               burst_left = $urandom_range(1, 12);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
            end
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_blocks.size() > 0) begin
               driven_block = pending_blocks.pop_front();
               req_valid <= 1'b1;
               req_func <= driven_block.func;
               req_data_hi <= driven_block.data_hi;
               req_data_lo <= driven_block.data_lo;
               if (burst_left > 0) burst_left--;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response stall pattern: modes from never stalled to long stretches of stall.
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_left = $urandom_range(10, 80);
      end
      stall_left--;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= ($urandom_range(0, 15) != 0);
      endcase
   end

   // Result checker.
   always @(posedge clock) begin
      block_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_blocks.size() == 0) begin
            $error("result transfer with no block outstanding: %h %h",
                   rsp_result_hi, rsp_result_lo);
            fail_count++;
         end else begin
            want = expected_blocks.pop_front();
            blocks_checked++;
            if (rsp_result_hi !== want.result_hi) begin
               $error("result_hi expected %h actual %h", want.result_hi, rsp_result_hi);
               fail_count++;
            end
            if (rsp_result_lo !== want.result_lo) begin
               $error("result_lo expected %h actual %h", want.result_lo, rsp_result_lo);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on cycles with no transfer on any channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d results outstanding", expected_blocks.size());
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic write_key(input logic [CSR_AW-1:0] idx, input logic [HALF_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      key_writes++;
      if (idx != CSR_UNMAPPED) begin
         key_words[idx] = value;
         expand_key_schedule();
      end
   endtask

   task automatic drain();
      while (pending_blocks.size() > 0 || req_valid || expected_blocks.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic queue_block(input logic func, input logic [HALF_W-1:0] hi,
                              input logic [HALF_W-1:0] lo);
      block_req_type b;
      b.func = func;
      b.data_hi = hi;
      b.data_lo = lo;
      pending_blocks.push_back(b);
   endtask

   function automatic logic [HALF_W-1:0] rand_word();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   initial begin
      logic [7:0] inv;
      for (int x = 0; x < 256; x++) begin
         inv = gf_invert(x[7:0]);
         fwd_sbox[x] = inv ^ rot8(inv, 1) ^ rot8(inv, 2) ^ rot8(inv, 3) ^ rot8(inv, 4) ^ 8'h63;
      end
      for (int x = 0; x < 256; x++) rev_sbox[fwd_sbox[x]] = x[7:0];
      for (int i = 0; i < 3; i++) key_words[i] = '0;
      for (int k = 0; k < NUM_RK; k++) begin
         enc_keys[k] = '0;
         dec_keys[k] = '0;
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Before any key write the rounds run with all-zero round keys.
      queue_block(1'b0, '0, '0);
      queue_block(1'b1, '0, '0);
      queue_block(1'b0, '1, '1);
      queue_block(1'b1, '1, '1);
      drain();

      // Standard AES-192 test key and plaintext, both directions.
      write_key(CSR_KEY_HIGH, 64'h0001020304050607);
      write_key(CSR_KEY_MIDDLE, 64'h08090a0b0c0d0e0f);
      write_key(CSR_KEY_LOW, 64'h1011121314151617);
      queue_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
      queue_block(1'b1, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191);
      queue_block(1'b0, '1, '0);
      queue_block(1'b1, '0, '1);
      drain();

      // Unmapped index leaves the schedule alone; a single word rewrite re-expands.
      write_key(CSR_UNMAPPED, '1);
      queue_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
      drain();
      write_key(CSR_KEY_MIDDLE, '1);
      queue_block(1'b0, 64'h0011223344556677, 64'h8899aabbccddeeff);
      queue_block(1'b1, 64'h0011223344556677, 64'h8899aabbccddeeff);
      drain();

      // All-ones and all-zero keys.
      write_key(CSR_KEY_HIGH, '1);
      write_key(CSR_KEY_LOW, '1);
      queue_block(1'b0, '0, '0);
      queue_block(1'b1, '1, '1);
      queue_block(1'b0, 64'h8000000000000000, 64'h0000000000000001);
      drain();
      write_key(CSR_KEY_HIGH, '0);
      write_key(CSR_KEY_MIDDLE, '0);
      write_key(CSR_KEY_LOW, '0);
      queue_block(1'b0, '0, '0);
      queue_block(1'b1, '0, '0);
      queue_block(1'b1, 64'h0000000000000001, 64'h8000000000000000);
      drain();

      // Random phases: a fresh or partly rewritten key, then a run of blocks.
      for (int p = 0; p < 6; p++) begin
         for (int i = 0; i < 3; i++)
            if (p == 0 || $urandom_range(0, 2) != 0)
               write_key(i[CSR_AW-1:0], rand_word());
         if ($urandom_range(0, 3) == 0) write_key(CSR_UNMAPPED, rand_word());
         for (int n = 0; n < 95; n++)
            queue_block(1'($urandom_range(0, 1)), rand_word(), rand_word());
         drain();
      end

      $display("%0d blocks checked over %0d key register writes, both directions",
               blocks_checked, key_writes);
      if (fail_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
